/* rtl/token_classifying_lexer_defines.svh */
// ----------------------------------------------------------------------------
// token_classifying_lexer_defines
// Assertion macros used by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef TOKEN_CLASSIFYING_LEXER_DEFINES_SVH
`define TOKEN_CLASSIFYING_LEXER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TCL_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TCL_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcl_pkg.sv */
// ----------------------------------------------------------------------------
// tcl_pkg
// Types, constants and character classes of the token classifying lexer.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int TCL_KEYWORD_CHARS = 6;
  localparam int TCL_LENGTH_BITS   = 8;

  localparam int CHAR_W     = 8;
  localparam int LEN_OUT_W  = 8;
  localparam int KW_IDX_W   = 3;
  localparam int KW_COUNT   = 6;
  localparam int KW_MAXLEN  = 6;

  localparam logic [LEN_OUT_W-1:0] TOKEN_LEN_MAX = {LEN_OUT_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'd122;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0   = "0";
  localparam logic [CHAR_W-1:0] CH_DIGIT_9   = "9";
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = "_";
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

  // keywords in match order: if, else, int, float, double, while
  localparam logic [CHAR_W-1:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"e", "l", "s", "e", CH_NUL, CH_NUL},
    '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL},
    '{"f", "l", "o", "a", "t", CH_NUL},
    '{"d", "o", "u", "b", "l", "e"},
    '{"w", "h", "i", "l", "e", CH_NUL}
  };
  localparam int KW_LEN [KW_COUNT] = '{2, 4, 3, 5, 6, 5};

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PUSH_MAX   = 2;
  localparam int PUSH_CNT_W = $clog2(PUSH_MAX + 1);

  typedef enum logic [2:0] {
    CLS_NUMBER   = 3'd0,
    CLS_KEYWORD  = 3'd1,
    CLS_IDENT    = 3'd2,
    CLS_OPERATOR = 3'd3,
    CLS_PUNCT    = 3'd4
  } tok_class_t;

  typedef struct packed {
    tok_class_t              token_class;
    logic [LEN_OUT_W-1:0]    token_length;
    logic [CHAR_W-1:0]       symbol;
    logic [KW_IDX_W-1:0]     keyword_index;
    logic                    last;
  } tcl_result_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] free;
    logic                  empty;
  } fifo_status_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
  endfunction

  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDERSCORE;
  endfunction

  function automatic logic is_operator(input logic [CHAR_W-1:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "=";
  endfunction

  function automatic logic is_punct(input logic [CHAR_W-1:0] c);
    return c == "#" || c == ";" || c == ":" || c == "." || c == "!" ||
           c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
           c == "}" || c == "<" || c == ">";
  endfunction

endpackage

/* rtl/tcl_in_if.sv */
// ----------------------------------------------------------------------------
// tcl_in_if
// Byte channel into the lexer: valid/ready with one text byte.
// ----------------------------------------------------------------------------
interface tcl_in_if import tcl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

/* rtl/tcl_out_if.sv */
// ----------------------------------------------------------------------------
// tcl_out_if
// Token channel out of the lexer: valid/ready with one classified token.
// ----------------------------------------------------------------------------
interface tcl_out_if import tcl_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [2:0]           token_class;
  logic [LEN_OUT_W-1:0] token_length;
  logic [CHAR_W-1:0]    symbol;
  logic [KW_IDX_W-1:0]  keyword_index;
  logic                 last;

  modport source (output valid, output token_class, output token_length,
                  output symbol, output keyword_index, output last, input ready);
  modport sink   (input valid, input token_class, input token_length,
                  input symbol, input keyword_index, input last, output ready);
endinterface

/* rtl/tcl_word_unit.sv */
// ----------------------------------------------------------------------------
// tcl_word_unit
// Holds the pending word and classifies it when a closing byte arrives,
// producing up to two tokens for one byte.
// ----------------------------------------------------------------------------
module tcl_word_unit import tcl_pkg::*; #(
  parameter int KEYWORD_CHARS = TCL_KEYWORD_CHARS,
  parameter int LENGTH_BITS   = TCL_LENGTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [CHAR_W-1:0]     char_code,
  output tcl_result_t           res0,
  output tcl_result_t           res1,
  output logic [PUSH_CNT_W-1:0] res_cnt
);

  localparam int PREFIX_IDX_W = $clog2(KEYWORD_CHARS);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0] word_len_r, word_len_nxt;
  logic                   starts_digit_r, starts_digit_nxt;
  logic                   non_letter_r, non_letter_nxt;
  logic [CHAR_W-1:0]      prefix_r [KEYWORD_CHARS];

  logic                    c_letter, c_digit, c_word;
  logic                    prefix_we;
  logic [PREFIX_IDX_W-1:0] prefix_idx;
  logic [KW_COUNT-1:0]     kw_hit;
  logic                    kw_any;
  logic [KW_IDX_W-1:0]     kw_idx;
  logic                    word_emit, sym_emit;
  tcl_result_t             word_res, sym_res;

  assign c_letter   = is_letter(char_code);
  assign c_digit    = is_digit(char_code);
  assign c_word     = is_word_char(char_code);
  assign prefix_idx = PREFIX_IDX_W'(word_len_r);

  // state update
  always_comb begin
    word_len_nxt     = word_len_r;
    starts_digit_nxt = starts_digit_r;
    non_letter_nxt   = non_letter_r;
    prefix_we        = 1'b0;
    if (step) begin
      if (c_word) begin
        if (word_len_r == '0) begin
          starts_digit_nxt = c_digit;
        end
        if (!c_letter) begin
          non_letter_nxt = 1'b1;
        end
        if (32'(word_len_r) < KEYWORD_CHARS) begin
          prefix_we = 1'b1;
        end
        if (word_len_r != LEN_MAX) begin
          word_len_nxt = word_len_r + LENGTH_BITS'(1);
        end
      end else begin
        word_len_nxt     = '0;
        starts_digit_nxt = 1'b0;
        non_letter_nxt   = 1'b0;
      end
    end
  end

  // keyword compare against the stored prefix
  always_comb begin
    kw_hit = '0;
    kw_idx = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_hit[k] = (32'(word_len_r) == KW_LEN[k]);
      for (int j = 0; j < KW_MAXLEN; j++) begin
        if (j < KW_LEN[k] && prefix_r[j] != KW_TEXT[k][j]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        kw_idx = KW_IDX_W'(k);
      end
    end
  end
  assign kw_any = |kw_hit;

  always_comb begin
    word_emit = !c_word && (word_len_r != '0) && (starts_digit_r || kw_any || !non_letter_r);
    sym_emit  = !c_word && (is_operator(char_code) || is_punct(char_code));

    word_res.token_length  = (32'(word_len_r) > 32'(TOKEN_LEN_MAX)) ? TOKEN_LEN_MAX
                                                                     : LEN_OUT_W'(word_len_r);
    word_res.symbol        = '0;
    word_res.last          = !sym_emit;
    if (starts_digit_r) begin
      word_res.token_class   = CLS_NUMBER;
      word_res.keyword_index = '0;
    end else if (kw_any) begin
      word_res.token_class   = CLS_KEYWORD;
      word_res.keyword_index = kw_idx;
    end else begin
      word_res.token_class   = CLS_IDENT;
      word_res.keyword_index = '0;
    end

    sym_res.token_class   = is_operator(char_code) ? CLS_OPERATOR : CLS_PUNCT;
    sym_res.token_length  = LEN_OUT_W'(1);
    sym_res.symbol        = char_code;
    sym_res.keyword_index = '0;
    sym_res.last          = 1'b1;

    res0    = word_emit ? word_res : sym_res;
    res1    = sym_res;
    res_cnt = PUSH_CNT_W'(word_emit) + PUSH_CNT_W'(sym_emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_len_r     <= '0;
      starts_digit_r <= 1'b0;
      non_letter_r   <= 1'b0;
    end else begin
      word_len_r     <= word_len_nxt;
      starts_digit_r <= starts_digit_nxt;
      non_letter_r   <= non_letter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (prefix_we) begin
      prefix_r[prefix_idx] <= char_code;
    end
  end

endmodule

/* rtl/tcl_result_fifo.sv */
// ----------------------------------------------------------------------------
// tcl_result_fifo
// Small token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module tcl_result_fifo import tcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [PUSH_CNT_W-1:0] push_cnt,
  input  tcl_result_t           push0,
  input  tcl_result_t           push1,
  input  logic                  pop,
  output tcl_result_t           head_data,
  output fifo_status_t          stat
);

  tcl_result_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   head_r, head_nxt;
  logic [FIFO_PTR_W-1:0]   tail_r, tail_nxt;
  logic [FIFO_PTR_W-1:0]   tail_plus1;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;

  assign tail_plus1 = tail_r + FIFO_PTR_W'(1);
  assign head_data  = mem_r[head_r];
  assign stat.free  = FIFO_CNT_W'(FIFO_DEPTH) - count_r;
  assign stat.empty = (count_r == '0);

  always_comb begin
    tail_nxt  = tail_r + FIFO_PTR_W'(push_cnt);
    head_nxt  = head_r + FIFO_PTR_W'(pop);
    count_nxt = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != '0) begin
      mem_r[tail_r] <= push0;
    end
    if (push_cnt == PUSH_CNT_W'(PUSH_MAX)) begin
      mem_r[tail_plus1] <= push1;
    end
  end

endmodule

/* rtl/token_classifying_lexer.sv */
// ----------------------------------------------------------------------------
// token_classifying_lexer
// Byte-stream lexer that classifies words, operators and punctuation.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room. A byte is registered, then
// classified against the pending word in one pass, and its tokens (none, one or
// two) go into a four-entry queue that the output drains at one token per cycle
// while out_ch.ready is high. A byte passes the stage register, then the queue,
// before its first token shows on the output. Input flows at one byte per cycle
// as long as the output keeps up; a byte that yields two tokens takes the output
// port once per token, so sustained throughput is bounded by the single-token
// output port, and the input stalls when fewer than two queue entries are free.
`include "token_classifying_lexer_defines.svh"

module token_classifying_lexer import tcl_pkg::*; #(
  parameter int KEYWORD_CHARS = TCL_KEYWORD_CHARS,
  parameter int LENGTH_BITS   = TCL_LENGTH_BITS
) (
  input logic       clk,
  input logic       rst_n,
  tcl_in_if.sink    in_ch,
  tcl_out_if.source out_ch
);

  logic              stage_valid_r, stage_valid_nxt;
  logic [CHAR_W-1:0] stage_char_r, stage_char_nxt;
  logic              stage_fire;
  logic              in_xfer;
  logic              pop;

  tcl_result_t             push0, push1, head_data;
  logic [PUSH_CNT_W-1:0]   push_cnt, res_cnt;
  fifo_status_t            fifo_stat;

  // fire only with room for the largest token burst
  assign stage_fire  = stage_valid_r && (fifo_stat.free >= FIFO_CNT_W'(PUSH_MAX));
  assign in_ch.ready = !stage_valid_r || stage_fire;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign push_cnt    = stage_fire ? res_cnt : '0;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_char_nxt  = stage_char_r;
    if (in_xfer) begin
      stage_valid_nxt = 1'b1;
      stage_char_nxt  = in_ch.char_code;
    end else if (stage_fire) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_char_r <= stage_char_nxt;
  end

  tcl_word_unit #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_word (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (stage_fire),
    .char_code (stage_char_r),
    .res0      (push0),
    .res1      (push1),
    .res_cnt   (res_cnt)
  );

  tcl_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .pop       (pop),
    .head_data (head_data),
    .stat      (fifo_stat)
  );

  assign out_ch.valid         = !fifo_stat.empty;
  assign pop                  = out_ch.valid && out_ch.ready;
  assign out_ch.token_class   = head_data.token_class;
  assign out_ch.token_length  = head_data.token_length;
  assign out_ch.symbol        = head_data.symbol;
  assign out_ch.keyword_index = head_data.keyword_index;
  assign out_ch.last          = head_data.last;

  `TCL_ASSERT_IMPLIES(a_word_char_silent, clk, rst_n, stage_fire && is_word_char(stage_char_r), push_cnt == '0, "word byte produced a token")
  `TCL_ASSERT_IMPLIES(a_pair_last, clk, rst_n, push_cnt == PUSH_CNT_W'(PUSH_MAX), push1.last && !push0.last, "bad last marks on token pair")
  `TCL_ASSERT_IMPLIES(a_single_last, clk, rst_n, push_cnt == PUSH_CNT_W'(1), push0.last, "single token lacks last mark")
  `TCL_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_r && !stage_fire, stage_valid_r && $stable(stage_char_r), "stalled byte lost")

endmodule
